// ===== design/rtn_pkg.sv =====
// shared types and constants for the ray-triangle nearest hit block
// no dependencies
package rtn_pkg;

  localparam int CoordW      = 32;
  localparam int EdgeW       = 33;
  localparam int WideW       = 67;
  localparam int AccW        = 104;
  localparam int MulW        = 35;
  localparam int ProdW       = 70;
  localparam int SplitW      = 34;
  localparam int OrdW        = 16;
  localparam int BaryW       = 17;
  localparam int QuoW        = 32;
  localparam int CfgIdxW     = 4;
  localparam int FaceCmpW    = 25;
  localparam int DefMaxFaces = 65536;
  localparam int DefFracBits = 16;
  localparam int DefQueueDepth = 2;
  localparam int BaryFrac    = 16;

  localparam logic [CoordW-1:0] ThreshReset = 32'd2814750;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORG_X  = 4'd0,
    REG_ORG_Y  = 4'd1,
    REG_ORG_Z  = 4'd2,
    REG_DIR_X  = 4'd3,
    REG_DIR_Y  = 4'd4,
    REG_DIR_Z  = 4'd5,
    REG_MAXD   = 4'd6,
    REG_THRESH = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][EdgeW-1:0] e1;
    logic [2:0][EdgeW-1:0] e2;
    logic [2:0][EdgeW-1:0] tv;
    logic [OrdW-1:0]       ordinal;
    logic                  first;
    logic                  last;
  } tri_entry_t;

  typedef struct packed {
    logic [2:0][CoordW-1:0] dir;
    logic [CoordW-1:0]      max_dist;
    logic [CoordW-1:0]      thresh;
  } ray_cfg_t;

endpackage

// ===== design/ray_triangle_nearest_hit.sv =====
// ray-triangle nearest hit: one triangle at a time; a miss ends after the hit test, a hit
// divides for the distance (early out on saturation), a new nearest hit also for u and v
// the shared 35x35 multiply-accumulate unit takes 36 steps per triangle and the
// bit-serial divider computes each quotient in turn (distance, then u and v on a new nearest)
// reset restores the register defaults, empties the queue and sets the best distance to all ones
module ray_triangle_nearest_hit #(
  parameter int MAX_FACES       = rtn_pkg::DefMaxFaces,
  parameter int COORD_FRAC_BITS = rtn_pkg::DefFracBits,
  parameter int QUEUE_DEPTH     = rtn_pkg::DefQueueDepth
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [rtn_pkg::CoordW-1:0] in_v0_x,
  input  logic signed [rtn_pkg::CoordW-1:0] in_v0_y,
  input  logic signed [rtn_pkg::CoordW-1:0] in_v0_z,
  input  logic signed [rtn_pkg::CoordW-1:0] in_v1_x,
  input  logic signed [rtn_pkg::CoordW-1:0] in_v1_y,
  input  logic signed [rtn_pkg::CoordW-1:0] in_v1_z,
  input  logic signed [rtn_pkg::CoordW-1:0] in_v2_x,
  input  logic signed [rtn_pkg::CoordW-1:0] in_v2_y,
  input  logic signed [rtn_pkg::CoordW-1:0] in_v2_z,
  input  logic                              in_first_triangle,
  input  logic                              in_last_triangle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit_found,
  output logic [rtn_pkg::CoordW-1:0]        out_hit_distance,
  output logic [rtn_pkg::BaryW-1:0]         out_hit_u,
  output logic [rtn_pkg::BaryW-1:0]         out_hit_v,
  output logic [rtn_pkg::OrdW-1:0]          out_hit_triangle,
  input  logic                              cfg_we,
  input  logic [rtn_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [rtn_pkg::CoordW-1:0]        cfg_wdata
);
  import rtn_pkg::*;

  logic [2:0][CoordW-1:0] org_r;
  logic [2:0][CoordW-1:0] dir_r;
  logic [CoordW-1:0]      maxd_r;
  logic [CoordW-1:0]      thr_r;
  ray_cfg_t               ray;
  logic                   q_push, q_pop, q_full, q_empty;
  tri_entry_t             q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r  <= '0;
      dir_r  <= '0;
      maxd_r <= '1;
      thr_r  <= ThreshReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORG_X:  org_r[0] <= cfg_wdata;
        REG_ORG_Y:  org_r[1] <= cfg_wdata;
        REG_ORG_Z:  org_r[2] <= cfg_wdata;
        REG_DIR_X:  dir_r[0] <= cfg_wdata;
        REG_DIR_Y:  dir_r[1] <= cfg_wdata;
        REG_DIR_Z:  dir_r[2] <= cfg_wdata;
        REG_MAXD:   maxd_r   <= cfg_wdata;
        REG_THRESH: thr_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ray.dir      = dir_r;
  assign ray.max_dist = maxd_r;
  assign ray.thresh   = thr_r;

  rtn_front #(
    .MAX_FACES (MAX_FACES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .v0_x           (in_v0_x),
    .v0_y           (in_v0_y),
    .v0_z           (in_v0_z),
    .v1_x           (in_v1_x),
    .v1_y           (in_v1_y),
    .v1_z           (in_v1_z),
    .v2_x           (in_v2_x),
    .v2_y           (in_v2_y),
    .v2_z           (in_v2_z),
    .first_triangle (in_first_triangle),
    .last_triangle  (in_last_triangle),
    .org            (org_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  rtn_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  rtn_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .ray              (ray),
    .q_empty          (q_empty),
    .q_data           (q_out),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit_found    (out_hit_found),
    .out_hit_distance (out_hit_distance),
    .out_hit_u        (out_hit_u),
    .out_hit_v        (out_hit_v),
    .out_hit_triangle (out_hit_triangle)
  );

endmodule

// ===== design/rtn_div.sv =====
// bit-serial restoring divider with saturation, one quotient bit per cycle
// depends on rtn_pkg
module rtn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rtn_pkg::AccW-1:0]  num_hi,
  input  logic [rtn_pkg::QuoW-1:0]  num_lo,
  input  logic [rtn_pkg::AccW-1:0]  den,
  output logic                      done,
  output logic [rtn_pkg::QuoW-1:0]  quo
);
  import rtn_pkg::*;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t           state_r;
  logic              done_r;
  logic              sat_r;
  logic [AccW-1:0]   rem_r;
  logic [QuoW-1:0]   lo_r;
  logic [QuoW-1:0]   quo_r;
  logic [4:0]        cnt_r;
  logic [AccW-1:0]   rem_sh;
  logic [AccW-1:0]   rem_nxt;
  logic              qbit;

  always_comb begin
    rem_sh  = {rem_r[AccW-2:0], lo_r[QuoW-1]};
    qbit    = rem_sh >= den;
    rem_nxt = qbit ? rem_sh - den : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            rem_r   <= num_hi;
            lo_r    <= num_lo;
            sat_r   <= num_hi >= den;
            cnt_r   <= '0;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          if (sat_r) begin
            quo_r   <= '1;
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end else begin
            rem_r <= rem_nxt;
            lo_r  <= {lo_r[QuoW-2:0], 1'b0};
            quo_r <= {quo_r[QuoW-2:0], qbit};
            cnt_r <= cnt_r + 5'd1;
            if (cnt_r == 5'd31) begin
              done_r  <= 1'b1;
              state_r <= D_IDLE;
            end
          end
        end
      endcase
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== design/rtn_front.sv =====
// front end: takes triangles, forms edge vectors, the origin offset and ordinals
// depends on rtn_pkg
module rtn_front #(
  parameter int MAX_FACES = rtn_pkg::DefMaxFaces
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [rtn_pkg::CoordW-1:0] v0_x,
  input  logic signed [rtn_pkg::CoordW-1:0] v0_y,
  input  logic signed [rtn_pkg::CoordW-1:0] v0_z,
  input  logic signed [rtn_pkg::CoordW-1:0] v1_x,
  input  logic signed [rtn_pkg::CoordW-1:0] v1_y,
  input  logic signed [rtn_pkg::CoordW-1:0] v1_z,
  input  logic signed [rtn_pkg::CoordW-1:0] v2_x,
  input  logic signed [rtn_pkg::CoordW-1:0] v2_y,
  input  logic signed [rtn_pkg::CoordW-1:0] v2_z,
  input  logic                             first_triangle,
  input  logic                             last_triangle,
  input  logic [2:0][rtn_pkg::CoordW-1:0]   org,
  input  logic                             q_full,
  output logic                             q_push,
  output rtn_pkg::tri_entry_t              q_data
);
  import rtn_pkg::*;

  localparam logic [FaceCmpW-1:0] MaxF = FaceCmpW'(MAX_FACES);

  logic [OrdW-1:0]     cnt_r;
  logic [OrdW-1:0]     ord;
  logic [OrdW:0]       nxt_wide;
  logic [OrdW-1:0]     cnt_nxt;
  logic [2:0][CoordW-1:0] p0, p1, p2;

  assign p0 = {v0_z, v0_y, v0_x};
  assign p1 = {v1_z, v1_y, v1_x};
  assign p2 = {v2_z, v2_y, v2_x};

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    ord      = first_triangle ? '0 : cnt_r;
    nxt_wide = {1'b0, ord} + 1'b1;
    cnt_nxt  = ({{(FaceCmpW-OrdW-1){1'b0}}, nxt_wide} >= MaxF) ? '0 : nxt_wide[OrdW-1:0];
    for (int i = 0; i < 3; i++) begin
      q_data.e1[i] = {p1[i][CoordW-1], p1[i]} - {p0[i][CoordW-1], p0[i]};
      q_data.e2[i] = {p2[i][CoordW-1], p2[i]} - {p0[i][CoordW-1], p0[i]};
      q_data.tv[i] = {org[i][CoordW-1], org[i]} - {p0[i][CoordW-1], p0[i]};
    end
    q_data.ordinal = ord;
    q_data.first   = first_triangle;
    q_data.last    = last_triangle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_push) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/rtn_fifo.sv =====
// short queue of prepared triangles between front and back
// depends on rtn_pkg
module rtn_fifo #(
  parameter int DEPTH = rtn_pkg::DefQueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rtn_pkg::tri_entry_t din,
  input  logic                pop,
  output rtn_pkg::tri_entry_t dout,
  output logic                full,
  output logic                empty
);
  import rtn_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [AW:0]   DepthC  = (AW+1)'(DEPTH);

  tri_entry_t        mem_r [DEPTH];
  logic [AW-1:0]     wr_r, rd_r;
  logic [AW:0]       cnt_r;

  assign full  = cnt_r == DepthC;
  assign empty = cnt_r == '0;
  assign dout  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == LastPtr) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == LastPtr) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/rtn_back.sv =====
// back end: multiply-accumulate sequencer, hit tests, division and nearest-hit state
// depends on rtn_pkg and rtn_div
module rtn_back #(
  parameter int COORD_FRAC_BITS = rtn_pkg::DefFracBits
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rtn_pkg::ray_cfg_t          ray,
  input  logic                       q_empty,
  input  rtn_pkg::tri_entry_t        q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit_found,
  output logic [rtn_pkg::CoordW-1:0] out_hit_distance,
  output logic [rtn_pkg::BaryW-1:0]  out_hit_u,
  output logic [rtn_pkg::BaryW-1:0]  out_hit_v,
  output logic [rtn_pkg::OrdW-1:0]   out_hit_triangle
);
  import rtn_pkg::*;

  localparam int TShift = QuoW - COORD_FRAC_BITS;
  localparam int UShift = QuoW - BaryFrac;

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_DRAIN, S_CORR, S_TEST, S_DIVT, S_DIVU, S_DIVV, S_FIN
  } state_t;

  typedef enum logic [2:0] {G_PV, G_QV, G_DET, G_NU, G_NV, G_NT} grp_t;

  typedef struct packed {
    logic       vld;
    logic       neg;
    logic       hi;
    logic       clr;
    logic       wr;
    grp_t       grp;
    logic [1:0] comp;
  } mac_ctl_t;

  function automatic logic [1:0] rot3(input logic [1:0] c, input logic [1:0] k);
    logic [2:0] s;
    s = {1'b0, c} + {1'b0, k};
    rot3 = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  state_t                 state_r;
  grp_t                   grp_r;
  logic [2:0]             j_r;
  tri_entry_t             ent_r;
  logic [2:0][WideW-1:0]  pv_r, qv_r;
  logic [AccW-1:0]        acc_r;
  logic signed [AccW-1:0] det_r, nu_r, nv_r, nt_r;
  logic signed [ProdW-1:0] prod_r;
  mac_ctl_t               ctl_r;
  logic [CoordW-1:0]      best_dist_r;
  logic [BaryW-1:0]       best_u_r, best_v_r;
  logic [OrdW-1:0]        best_tri_r;
  logic                   any_hit_r;
  logic [QuoW-1:0]        tq_r;
  logic [BaryW-1:0]       u_r;
  logic                   div_start_r;
  logic [AccW-1:0]        div_hi_r;
  logic [QuoW-1:0]        div_lo_r;
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [CoordW-1:0]      out_dist_r;
  logic [BaryW-1:0]       out_u_r, out_v_r;
  logic [OrdW-1:0]        out_tri_r;

  logic                   cross_grp;
  logic [1:0]             comp, ai, bi;
  logic [2:0][EdgeW-1:0]  dir_ext, avec;
  logic [EdgeW-1:0]       a_val, b_small;
  logic [WideW-1:0]       b_wide;
  logic [MulW-1:0]        mul_a, mul_b;
  logic signed [ProdW-1:0] prod_nxt;
  mac_ctl_t               ctl_nxt;
  logic [AccW-1:0]        term, acc_nxt;
  logic                   miss;
  logic                   emit;
  logic                   div_done;
  logic [QuoW-1:0]        div_q;
  logic [AccW-1:0]        nt_shl, nu_shl, nv_shl;

  assign q_pop = (state_r == S_IDLE) && !q_empty;
  assign emit  = (state_r == S_FIN) && ent_r.last && (!out_valid_r || !out_stall);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_ext[i] = {ray.dir[i][CoordW-1], ray.dir[i]};
    end
    cross_grp = (grp_r == G_PV) || (grp_r == G_QV);
    comp      = j_r[2:1];
    if (cross_grp) begin
      ai = j_r[0] ? rot3(comp, 2'd2) : rot3(comp, 2'd1);
      bi = j_r[0] ? rot3(comp, 2'd1) : rot3(comp, 2'd2);
    end else begin
      ai = comp;
      bi = comp;
    end
    unique case (grp_r)
      G_PV, G_NV: avec = dir_ext;
      G_QV, G_NU: avec = ent_r.tv;
      G_DET:      avec = ent_r.e1;
      default:    avec = ent_r.e2;
    endcase
    a_val   = avec[ai];
    b_small = (grp_r == G_PV) ? ent_r.e2[bi] : ent_r.e1[bi];
    b_wide  = ((grp_r == G_DET) || (grp_r == G_NU)) ? pv_r[bi] : qv_r[bi];
    mul_a   = {{(MulW-EdgeW){a_val[EdgeW-1]}}, a_val};
    if (cross_grp) begin
      mul_b = {{(MulW-EdgeW){b_small[EdgeW-1]}}, b_small};
    end else if (j_r[0]) begin
      mul_b = {{(MulW-(WideW-SplitW)){b_wide[WideW-1]}}, b_wide[WideW-1:SplitW]};
    end else begin
      mul_b = {{(MulW-SplitW){1'b0}}, b_wide[SplitW-1:0]};
    end
    prod_nxt = $signed(mul_a) * $signed(mul_b);

    ctl_nxt.vld  = state_r == S_MAC;
    ctl_nxt.neg  = cross_grp && j_r[0];
    ctl_nxt.hi   = !cross_grp && j_r[0];
    ctl_nxt.clr  = cross_grp ? !j_r[0] : (j_r == 3'd0);
    ctl_nxt.wr   = cross_grp ? j_r[0] : (j_r == 3'd5);
    ctl_nxt.grp  = grp_r;
    ctl_nxt.comp = comp;
  end

  always_comb begin
    term = {{(AccW-ProdW){prod_r[ProdW-1]}}, prod_r};
    if (ctl_r.hi) begin
      term = term << SplitW;
    end
    if (ctl_r.neg) begin
      term = -term;
    end
    acc_nxt = (ctl_r.clr ? '0 : acc_r) + term;
  end

  always_comb begin
    miss = (det_r == '0)
        || ($unsigned(det_r) < {{(AccW-CoordW){1'b0}}, ray.thresh})
        || (nu_r < 0) || (nu_r > det_r)
        || (nv_r < 0) || ((nu_r + nv_r) > det_r)
        || (nt_r < 0);
    nt_shl = nt_r << COORD_FRAC_BITS;
    nu_shl = nu_r << BaryFrac;
    nv_shl = nv_r << BaryFrac;
  end

  rtn_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start_r),
    .num_hi (div_hi_r),
    .num_lo (div_lo_r),
    .den    (det_r),
    .done   (div_done),
    .quo    (div_q)
  );

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl_r.vld) begin
      acc_r <= acc_nxt;
      if (ctl_r.wr) begin
        unique case (ctl_r.grp)
          G_PV:    pv_r[ctl_r.comp] <= acc_nxt[WideW-1:0];
          G_QV:    qv_r[ctl_r.comp] <= acc_nxt[WideW-1:0];
          G_DET:   det_r <= acc_nxt;
          G_NU:    nu_r  <= acc_nxt;
          G_NV:    nv_r  <= acc_nxt;
          default: nt_r  <= acc_nxt;
        endcase
      end
    end else if (state_r == S_CORR && det_r < 0) begin
      det_r <= -det_r;
      nu_r  <= -nu_r;
      nv_r  <= -nv_r;
      nt_r  <= -nt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grp_r       <= G_PV;
      j_r         <= '0;
      ctl_r       <= '0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      best_dist_r <= '1;
      best_u_r    <= '0;
      best_v_r    <= '0;
      best_tri_r  <= '0;
      any_hit_r   <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      div_start_r <= 1'b0;
      if (out_valid_r && !out_stall && !emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            ent_r <= q_data;
            grp_r <= G_PV;
            j_r   <= '0;
            if (q_data.first) begin
              best_dist_r <= ray.max_dist;
              best_u_r    <= '0;
              best_v_r    <= '0;
              best_tri_r  <= '0;
              any_hit_r   <= 1'b0;
            end
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (j_r == 3'd5) begin
            j_r <= '0;
            if (grp_r == G_NT) begin
              state_r <= S_DRAIN;
            end else begin
              grp_r <= grp_t'(grp_r + 3'd1);
            end
          end else begin
            j_r <= j_r + 3'd1;
          end
        end
        S_DRAIN: state_r <= S_CORR;
        S_CORR:  state_r <= S_TEST;
        S_TEST: begin
          if (miss) begin
            state_r <= S_FIN;
          end else begin
            div_hi_r    <= nt_r >> TShift;
            div_lo_r    <= nt_shl[QuoW-1:0];
            div_start_r <= 1'b1;
            state_r     <= S_DIVT;
          end
        end
        S_DIVT: begin
          if (div_done) begin
            tq_r <= div_q;
            if (div_q < best_dist_r) begin
              div_hi_r    <= nu_r >> UShift;
              div_lo_r    <= nu_shl[QuoW-1:0];
              div_start_r <= 1'b1;
              state_r     <= S_DIVU;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_DIVU: begin
          if (div_done) begin
            u_r         <= div_q[BaryW-1:0];
            div_hi_r    <= nv_r >> UShift;
            div_lo_r    <= nv_shl[QuoW-1:0];
            div_start_r <= 1'b1;
            state_r     <= S_DIVV;
          end
        end
        S_DIVV: begin
          if (div_done) begin
            best_dist_r <= tq_r;
            best_u_r    <= u_r;
            best_v_r    <= div_q[BaryW-1:0];
            best_tri_r  <= ent_r.ordinal;
            any_hit_r   <= 1'b1;
            state_r     <= S_FIN;
          end
        end
        S_FIN: begin
          if (!ent_r.last) begin
            state_r <= S_IDLE;
          end else if (emit) begin
            out_valid_r <= 1'b1;
            out_found_r <= any_hit_r;
            out_dist_r  <= any_hit_r ? best_dist_r : '0;
            out_u_r     <= any_hit_r ? best_u_r : '0;
            out_v_r     <= any_hit_r ? best_v_r : '0;
            out_tri_r   <= any_hit_r ? best_tri_r : '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit_found    = out_found_r;
  assign out_hit_distance = out_dist_r;
  assign out_hit_u        = out_u_r;
  assign out_hit_v        = out_v_r;
  assign out_hit_triangle = out_tri_r;

endmodule
